// ===== rtl/xxtea_pkg.sv =====
// Shared types, constants and helpers for the XXTEA block cipher.
// Used by xxtea_round_unit and xxtea_block_cipher; depends on nothing.
`default_nettype none

package xxtea_pkg;

  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int ROUND_W          = 6;
  localparam int CFG_IDX_W        = 3;

  localparam logic [31:0] DELTA_WORD = 32'h9E37_79B9;
  localparam logic [31:0] DELTA_BYTE = 32'h0000_009E;
  localparam logic [31:0] MASK_BYTE  = 32'h0000_00FF;
  localparam logic [31:0] MASK_WORD  = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0  = 3'd0,
    CFG_KEY1  = 3'd1,
    CFG_KEY2  = 3'd2,
    CFG_KEY3  = 3'd3,
    CFG_DIR   = 3'd4,
    CFG_WIDTH = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PREP0,
    ST_PREP1,
    ST_PREP2,
    ST_MIX,
    ST_ADD,
    ST_EMIT_RD0,
    ST_EMIT_RD1,
    ST_EMIT
  } phase_t;

  // Control for one mixing step
  typedef struct packed {
    logic        bytes;
    logic [31:0] sum;
    logic [3:0]  pos;
  } mix_ctl_t;

  // Full rounds for a block of n elements: 6 + 52/n
  function automatic logic [ROUND_W-1:0] rounds_for(input logic [6:0] n);
    logic [ROUND_W-1:0] q;
    if (n >= 7'd53)      q = 6'd0;
    else if (n >= 7'd27) q = 6'd1;
    else if (n >= 7'd18) q = 6'd2;
    else if (n >= 7'd14) q = 6'd3;
    else if (n >= 7'd11) q = 6'd4;
    else if (n >= 7'd9)  q = 6'd5;
    else if (n == 7'd8)  q = 6'd6;
    else if (n == 7'd7)  q = 6'd7;
    else if (n == 7'd6)  q = 6'd8;
    else if (n == 7'd5)  q = 6'd10;
    else if (n == 7'd4)  q = 6'd13;
    else if (n == 7'd3)  q = 6'd17;
    else                 q = 6'd26;
    return q + 6'd6;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/xxtea_block_cipher.sv =====
// XXTEA block cipher: element store, round sequencer and output stage.
// Depends on xxtea_pkg and xxtea_round_unit.
//
// Usage: elements stream in on the in_ channel (tdata = element, tlast marks
// the last element of a block), one beat per cycle while in_tready is high.
// After the last beat the block is encrypted or decrypted in place and then
// streamed out on the out_ channel in original order, out_tlast on the final
// element and out_tuser set on every element of a block that overflowed.
// Timing: a block of n >= 2 elements passes the setup states ST_PREP0 to
// ST_PREP2, then ST_MIX and ST_ADD per element in each of (6 + 52/n) rounds;
// the loop through the round unit and the single-port store sets this pace.
// Output follows store reads in ST_EMIT_RD0 and ST_EMIT_RD1 at up to one
// beat per cycle; one-element and overflowed blocks go straight to output.
// in_tready stays low from the last input beat until the final output beat
// is taken; a stalled receiver simply holds the block in the output stage.
// Reset clears the key, mode bits and all control state; the store needs no
// clearing. The cfg_ channel is always ready and must be written only while
// the block is idle.
`default_nettype none

module xxtea_block_cipher #(
  parameter int MAX_ELEMENTS = xxtea_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // [31:0] element
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // [31:0] result_element
  output logic                           out_tlast,
  output logic                           out_tuser,  // [0] too_long
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [xxtea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import xxtea_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_ELEMENTS);

  logic [31:0] mem [MAX_ELEMENTS];
  logic [31:0] rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0] wr_data;
  logic        mem_we;

  phase_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [31:0]   key_r [4];
  logic          dir_r, bytes_r;
  logic [ROUND_W-1:0] rounds_r, rounds_nxt;
  logic [31:0]   sum_r, sum_nxt;
  logic [AW-1:0] p_r, p_nxt;
  logic [31:0]   carry_r, carry_nxt;
  logic [31:0]   cur_r, cur_nxt;
  logic [31:0]   nb_r, nb_nxt;
  logic [31:0]   first_r, first_nxt;
  logic [31:0]   mix_r, mix_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_elem_r, out_elem_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_long_r, out_long_nxt;

  logic          enc, in_fire, out_fire, room, ovf_in;
  logic [CW-1:0] n_in;
  logic [31:0]   mask, delta, rd_q, nb_cur, mix_w, v_new;
  logic [AW-1:0] last_idx, prev_idx;
  logic          is_wrap, is_first;
  mix_ctl_t      ctl;

  assign in_tready  = (state_r == ST_LOAD);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_elem_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_long_r;

  assign enc      = !dir_r;
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_valid_r && out_tready;
  assign room     = (count_r < CAP);
  assign ovf_in   = ovf_r || !room;
  assign n_in     = room ? count_r + CW'(1) : count_r;
  assign mask     = bytes_r ? MASK_BYTE : MASK_WORD;
  assign delta    = bytes_r ? DELTA_BYTE : DELTA_WORD;
  assign rd_q     = rd_data_r & mask;
  assign last_idx = AW'(count_r - CW'(1));
  assign prev_idx = AW'(count_r - CW'(2));
  assign is_wrap  = enc ? (p_r == last_idx) : (p_r == '0);
  assign is_first = enc ? (p_r == '0) : (p_r == last_idx);
  // a block of two has one neighbor, the value written last; otherwise the
  // wrap step sees the value rewritten at the start of this round
  assign nb_cur   = (count_r == CW'(2)) ? carry_r : is_wrap ? first_r : rd_q;
  assign v_new    = (enc ? cur_r + mix_r : cur_r - mix_r) & mask;

  assign ctl.bytes = bytes_r;
  assign ctl.sum   = sum_r;
  assign ctl.pos   = 4'(p_r);

  xxtea_round_unit u_round (
    .ctl (ctl),
    .y   (enc ? nb_cur : carry_r),
    .z   (enc ? carry_r : nb_cur),
    .key ({key_r[3], key_r[2], key_r[1], key_r[0]}),
    .mix (mix_w)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire && in_tlast) begin
          state_nxt = (ovf_in || n_in < CW'(2)) ? ST_EMIT_RD0 : ST_PREP0;
        end
      end
      ST_PREP0:    state_nxt = ST_PREP1;
      ST_PREP1:    state_nxt = ST_PREP2;
      ST_PREP2:    state_nxt = ST_MIX;
      ST_MIX:      state_nxt = ST_ADD;
      ST_ADD: begin
        state_nxt = (is_wrap && rounds_r == ROUND_W'(1)) ? ST_EMIT_RD0 : ST_MIX;
      end
      ST_EMIT_RD0: state_nxt = ST_EMIT_RD1;
      ST_EMIT_RD1: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_fire && out_last_r) state_nxt = ST_LOAD;
      end
      default:     state_nxt = ST_LOAD;
    endcase
  end

  // Datapath and store control
  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    rounds_nxt    = rounds_r;
    sum_nxt       = sum_r;
    p_nxt         = p_r;
    carry_nxt     = carry_r;
    cur_nxt       = cur_r;
    nb_nxt        = nb_r;
    first_nxt     = first_r;
    mix_nxt       = mix_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_elem_nxt  = out_elem_r;
    out_last_nxt  = out_last_r;
    out_long_nxt  = out_long_r;
    rd_addr       = '0;
    wr_addr       = AW'(count_r);
    wr_data       = in_tdata;
    mem_we        = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (room) begin
            mem_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_PREP0: begin
        rd_addr    = enc ? last_idx : '0;
        rounds_nxt = rounds_for(7'(count_r));
        p_nxt      = enc ? '0 : last_idx;
      end
      ST_PREP1: begin
        rd_addr   = enc ? '0 : last_idx;
        carry_nxt = rd_q;
        sum_nxt   = enc ? (delta & mask) : ((32'(rounds_r) * delta) & mask);
      end
      ST_PREP2: begin
        rd_addr = enc ? AW'(1) : prev_idx;
        cur_nxt = rd_q;
      end
      ST_MIX: begin
        nb_nxt  = nb_cur;
        mix_nxt = mix_w;
      end
      ST_ADD: begin
        mem_we    = 1'b1;
        wr_addr   = p_r;
        wr_data   = v_new;
        carry_nxt = v_new;
        if (is_first) first_nxt = v_new;
        if (is_wrap) begin
          // start the next round at the same end of the block
          cur_nxt    = first_r;
          p_nxt      = enc ? '0 : last_idx;
          rounds_nxt = rounds_r - ROUND_W'(1);
          sum_nxt    = (enc ? sum_r + delta : sum_r - delta) & mask;
          rd_addr    = enc ? AW'(1) : prev_idx;
        end else begin
          cur_nxt = nb_r;
          p_nxt   = enc ? p_r + AW'(1) : p_r - AW'(1);
          rd_addr = enc ? p_r + AW'(2) : p_r - AW'(2);
        end
      end
      ST_EMIT_RD0: begin
        rd_addr = '0;
      end
      ST_EMIT_RD1: begin
        rd_addr       = AW'(1);
        out_valid_nxt = 1'b1;
        out_elem_nxt  = rd_q;
        out_last_nxt  = (count_r == CW'(1));
        out_long_nxt  = ovf_r;
        k_nxt         = '0;
      end
      ST_EMIT: begin
        // prefetch one element ahead of the output stage
        rd_addr = out_fire ? k_r + AW'(2) : k_r + AW'(1);
        if (out_fire) begin
          if (out_last_r) begin
            out_valid_nxt = 1'b0;
            count_nxt     = '0;
            ovf_nxt       = 1'b0;
          end else begin
            k_nxt        = k_r + AW'(1);
            out_elem_nxt = rd_q;
            out_last_nxt = (CW'(k_r) + CW'(2) == count_r);
          end
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Element store
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= '0;
      key_r[1] <= '0;
      key_r[2] <= '0;
      key_r[3] <= '0;
      dir_r    <= 1'b0;
      bytes_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY0:  key_r[0] <= cfg_data;
        CFG_KEY1:  key_r[1] <= cfg_data;
        CFG_KEY2:  key_r[2] <= cfg_data;
        CFG_KEY3:  key_r[3] <= cfg_data;
        CFG_DIR:   dir_r    <= cfg_data[0];
        CFG_WIDTH: bytes_r  <= cfg_data[0];
        default:   dir_r    <= dir_r;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    rounds_r   <= rounds_nxt;
    sum_r      <= sum_nxt;
    p_r        <= p_nxt;
    carry_r    <= carry_nxt;
    cur_r      <= cur_nxt;
    nb_r       <= nb_nxt;
    first_r    <= first_nxt;
    mix_r      <= mix_nxt;
    k_r        <= k_nxt;
    out_elem_r <= out_elem_nxt;
    out_last_r <= out_last_nxt;
    out_long_r <= out_long_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/xxtea_round_unit.sv =====
// XXTEA mixing function shared by every step of encrypt and decrypt.
// Depends on xxtea_pkg for the step control struct and masks.
`default_nettype none

module xxtea_round_unit (
  input  xxtea_pkg::mix_ctl_t ctl,
  input  logic [31:0]         y,
  input  logic [31:0]         z,
  input  logic [127:0]        key,
  output logic [31:0]         mix
);
  import xxtea_pkg::*;

  logic [1:0]  e;
  logic [3:0]  kidx;
  logic [31:0] kpart;
  logic [31:0] a, b, c, d;
  logic [31:0] mask;

  always_comb begin
    e     = ctl.sum[3:2];
    kidx  = ctl.pos ^ {2'b00, e};
    mask  = ctl.bytes ? MASK_BYTE : MASK_WORD;
    // byte mode reads the key as sixteen little-endian bytes
    kpart = ctl.bytes ? {24'h0, key[{kidx, 3'b000} +: 8]}
                      : key[{kidx[1:0], 5'b00000} +: 32];
    a     = (z >> 5) ^ (y << 2);
    b     = (y >> 3) ^ (z << 4);
    c     = ctl.sum ^ y;
    d     = kpart ^ z;
    mix   = ((a + b) ^ (c + d)) & mask;
  end

endmodule

`default_nettype wire

// ===== rtl/xxtea_checker.sv =====
// Port-level checks for xxtea_block_cipher, attached with a bind.
// Depends only on the top-level port names.
`default_nettype none

module xxtea_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        in_tlast,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata,
  input wire        out_tlast
);

  // input and output phases never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while output valid");

  // a closing input beat ends the load phase
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still ready after last beat");

  // input stays closed until the final output beat is taken
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !in_tready)
    else $error("input reopened in the middle of a block");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

endmodule

bind xxtea_block_cipher xxtea_checker u_checker (.*);

`default_nettype wire
